FILE: rtl/pwv_pkg.sv
// Shared constants for the per-pixel Welford variance block.
package pwv_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 1048576;
  localparam int unsigned MAX_FRAMES_DEF = 1023;

  localparam int PIX_W  = 16;
  localparam int IDX_W  = 20;
  localparam int MEAN_W = 32;
  localparam int SUM_W  = 58;
  localparam int FRM_W  = 10;
  localparam int CFG_W  = 21;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int DIV_W  = 32;

  localparam logic [SUM_W-1:0]  SUM_MAX         = '1;
  localparam logic [APB_AW-1:0] ADDR_PIXEL_COUNT = 3'd0;
  localparam logic [CFG_W-1:0]  PIXEL_COUNT_RST  = 21'd1048576;

endpackage

FILE: rtl/pwv_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
module pwv_divider #(
  parameter int NW = pwv_pkg::DIV_W,
  parameter int DW = 10,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  logic [NW-1:0] in_dvd,
  input  logic [DW-1:0] in_dvs,
  input  logic [PW-1:0] in_pay,
  output logic          out_v,
  output logic [NW-1:0] out_quo,
  output logic [PW-1:0] out_pay,
  output logic          busy
);

  logic          v_r   [NW];
  logic [NW-1:0] dvd_r [NW];
  logic [NW-1:0] quo_r [NW];
  logic [DW-1:0] rem_r [NW];
  logic [DW-1:0] dvs_r [NW];
  logic [PW-1:0] pay_r [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic          pv;
    logic [NW-1:0] pdvd;
    logic [NW-1:0] pquo;
    logic [DW-1:0] prem;
    logic [DW-1:0] pdvs;
    logic [PW-1:0] ppay;
    logic [DW:0]   trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign pv   = in_v;
      assign pdvd = in_dvd;
      assign pquo = '0;
      assign prem = '0;
      assign pdvs = in_dvs;
      assign ppay = in_pay;
    end else begin : g_next
      assign pv   = v_r[i-1];
      assign pdvd = dvd_r[i-1];
      assign pquo = quo_r[i-1];
      assign prem = rem_r[i-1];
      assign pdvs = dvs_r[i-1];
      assign ppay = pay_r[i-1];
    end

    assign trial = {prem, pdvd[NW-1]};
    assign ge    = trial >= {1'b0, pdvs};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= pv;
      end
      if (en) begin
        dvd_r[i] <= pdvd << 1;
        quo_r[i] <= {pquo[NW-2:0], ge};
        rem_r[i] <= ge ? DW'(trial - {1'b0, pdvs}) : trial[DW-1:0];
        dvs_r[i] <= pdvs;
        pay_r[i] <= ppay;
      end
    end
  end

  always_comb begin
    busy = 1'b0;
    for (int i = 0; i < NW; i++) begin
      busy = busy | v_r[i];
    end
  end

  assign out_v   = v_r[NW-1];
  assign out_quo = quo_r[NW-1];
  assign out_pay = pay_r[NW-1];

endmodule

FILE: rtl/per_pixel_welford_variance.sv
// Top level: per-pixel running mean and sum of squared deviations (Welford).
//
// Usage: pixels arrive in raster order on the in_ stream, one request per
// pixel; in_tuser[0] marks the first pixel of frame one of a new run. Each
// pixel yields one request on the out_ stream with its raster index, the
// updated Q16.16 mean, the Q42.16 sum of squared deviations (saturating),
// the frame number, tlast on the last pixel of a frame and tuser[0] when
// the frame count is held at its maximum. pixel_count is written over APB;
// the user must do so only while the block is idle; the block has no check.
// The pipeline is two front stages, a 32-stage quotient divider, a
// mean/deviation stage, a multiply stage and an output register.
// Throughput is one pixel per cycle while the receiver keeps up and the
// frame holds more pixels than the 36 stages in flight; smaller frames,
// and a restart while pixels are in flight, wait until the pipeline
// drains because the next pixel reads an entry an earlier pixel must write.
// Reset clears the position, the frame count, all valid bits and sets
// pixel_count to 1048576; the stores are not cleared (frame one ignores
// what it reads and writes every entry). When the receiver stalls the whole
// pipeline holds and in_tready drops; nothing is lost or repeated.
module per_pixel_welford_variance #(
  parameter int unsigned MAX_PIXELS = pwv_pkg::MAX_PIXELS_DEF,
  parameter int unsigned MAX_FRAMES = pwv_pkg::MAX_FRAMES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // tdata: pixel_value[15:0]
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,
  // tuser: restart[0]
  input  logic [0:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // tdata: pixel_index[19:0], mean_value[51:20], sum_sq_dev[109:52],
  //        frame_number[119:110]
  output logic [119:0]                out_tdata,
  output logic                        out_tlast,
  // tuser: count_saturated[0]
  output logic [0:0]                  out_tuser,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [pwv_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [pwv_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [pwv_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int AW = $clog2(MAX_PIXELS);
  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int KW = $clog2(MAX_FRAMES + 1);
  localparam int NW = pwv_pkg::DIV_W;
  localparam int PIPE_DEPTH = NW + 4;
  localparam int MW = pwv_pkg::MEAN_W;
  localparam int SW = pwv_pkg::SUM_W;

  typedef struct packed {
    logic [15:0]   x;
    logic [AW-1:0] pos;
    logic [KW-1:0] k;
    logic          last;
    logic          first;
    logic          up;
    logic [MW-1:0] mean;
    logic [SW-1:0] sum;
    logic [MW-1:0] mag1;
  } pay_t;

  // configuration
  logic [pwv_pkg::CFG_W-1:0] pixel_count_r;
  logic [CW-1:0]             eff_count;
  logic                      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite &
                  (cfg_paddr == pwv_pkg::ADDR_PIXEL_COUNT);
  assign cfg_prdata = (cfg_paddr == pwv_pkg::ADDR_PIXEL_COUNT) ?
                      pwv_pkg::APB_DW'(pixel_count_r) : '0;

  always_comb begin
    if (pixel_count_r == '0) begin
      eff_count = CW'(1);
    end else if (32'(pixel_count_r) > MAX_PIXELS) begin
      eff_count = CW'(MAX_PIXELS);
    end else begin
      eff_count = CW'(pixel_count_r);
    end
  end

  // pipeline control: the whole pipe advances when the output is free
  logic en, accept, busy, div_busy, hazard;
  logic s1_v_r, s2_v_r, a_v_r, m_v_r, out_v_r;

  assign en     = !out_v_r || out_tready;
  assign busy   = s1_v_r | s2_v_r | div_busy | a_v_r | m_v_r;
  // hold new pixels while an in-flight one may still own the same entry
  assign hazard = busy && (in_tuser[0] || (32'(eff_count) <= PIPE_DEPTH));
  assign in_tready = en && !hazard;
  assign accept    = in_tvalid && in_tready;

  // raster position and frame count
  logic [AW-1:0] pos_r, pos_use, pos_nxt;
  logic [KW-1:0] frames_r, frames_nxt, k_use;
  logic          last_use;

  always_comb begin
    pos_use    = in_tuser[0] ? '0 : pos_r;
    frames_nxt = frames_r;
    if (pos_use == '0) begin
      if (in_tuser[0]) begin
        frames_nxt = KW'(1);
      end else if (32'(frames_r) < MAX_FRAMES) begin
        frames_nxt = frames_r + KW'(1);
      end
    end
    k_use    = (frames_nxt == '0) ? KW'(1) : frames_nxt;
    last_use = (32'(pos_use) + 32'd1) >= 32'(eff_count);
    pos_nxt  = last_use ? '0 : pos_use + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      frames_r      <= '0;
      pixel_count_r <= pwv_pkg::PIXEL_COUNT_RST;
    end else begin
      if (accept) begin
        pos_r    <= pos_nxt;
        frames_r <= frames_nxt;
      end
      if (cfg_wr) begin
        pixel_count_r <= cfg_pwdata[pwv_pkg::CFG_W-1:0];
      end
    end
  end

  // stores: read at accept, written when the result is formed
  logic [MW-1:0] mean_mem [MAX_PIXELS];
  logic [SW-1:0] dev_mem  [MAX_PIXELS];
  logic [MW-1:0] rd_mean_r;
  logic [SW-1:0] rd_sum_r;

  // stage 1
  logic [15:0]   s1_x_r;
  logic [AW-1:0] s1_pos_r;
  logic [KW-1:0] s1_k_r;
  logic          s1_last_r, s1_first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= accept;
    end
    if (en) begin
      rd_mean_r  <= mean_mem[pos_use];
      rd_sum_r   <= dev_mem[pos_use];
      s1_x_r     <= in_tdata;
      s1_pos_r   <= pos_use;
      s1_k_r     <= k_use;
      s1_last_r  <= last_use;
      s1_first_r <= (k_use == KW'(1));
    end
  end

  // stage 2: first deviation magnitude and its sign
  logic [MW-1:0] s1_bigx;
  logic          s1_up;
  pay_t          s2_pay_r;

  assign s1_bigx = {s1_x_r, 16'h0000};
  assign s1_up   = s1_bigx >= rd_mean_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
    if (en) begin
      s2_pay_r.x     <= s1_x_r;
      s2_pay_r.pos   <= s1_pos_r;
      s2_pay_r.k     <= s1_k_r;
      s2_pay_r.last  <= s1_last_r;
      s2_pay_r.first <= s1_first_r;
      s2_pay_r.up    <= s1_up;
      s2_pay_r.mean  <= rd_mean_r;
      s2_pay_r.sum   <= rd_sum_r;
      s2_pay_r.mag1  <= s1_up ? s1_bigx - rd_mean_r : rd_mean_r - s1_bigx;
    end
  end

  // quotient delta / k
  logic          d_v;
  logic [NW-1:0] d_quo;
  logic [$bits(pay_t)-1:0] d_pay_bits;
  pay_t          d_pay;

  pwv_divider #(
    .NW (NW),
    .DW (KW),
    .PW ($bits(pay_t))
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (s2_v_r),
    .in_dvd  (s2_pay_r.mag1),
    .in_dvs  (s2_pay_r.k),
    .in_pay  (s2_pay_r),
    .out_v   (d_v),
    .out_quo (d_quo),
    .out_pay (d_pay_bits),
    .busy    (div_busy)
  );

  assign d_pay = pay_t'(d_pay_bits);

  // stage A: new mean and second deviation magnitude
  logic [MW-1:0] d_bigx, d_mean_new;
  logic [MW-1:0] a_mean_r, a_mag1_r, a_mag2_r;
  logic [SW-1:0] a_sum_r;
  logic [AW-1:0] a_pos_r;
  logic [KW-1:0] a_k_r;
  logic          a_last_r, a_first_r;

  assign d_bigx     = {d_pay.x, 16'h0000};
  assign d_mean_new = d_pay.first ? d_bigx :
                      d_pay.up ? d_pay.mean + d_quo : d_pay.mean - d_quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= d_v;
    end
    if (en) begin
      a_mean_r  <= d_mean_new;
      a_mag1_r  <= d_pay.mag1;
      a_mag2_r  <= d_pay.up ? d_bigx - d_mean_new : d_mean_new - d_bigx;
      a_sum_r   <= d_pay.sum;
      a_pos_r   <= d_pay.pos;
      a_k_r     <= d_pay.k;
      a_last_r  <= d_pay.last;
      a_first_r <= d_pay.first;
    end
  end

  // stage M: deviation product
  logic [2*MW-1:0] m_prod_r;
  logic [MW-1:0]   m_mean_r;
  logic [SW-1:0]   m_sum_r;
  logic [AW-1:0]   m_pos_r;
  logic [KW-1:0]   m_k_r;
  logic            m_last_r, m_first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= a_v_r;
    end
    if (en) begin
      m_prod_r  <= a_mag1_r * a_mag2_r;
      m_mean_r  <= a_mean_r;
      m_sum_r   <= a_sum_r;
      m_pos_r   <= a_pos_r;
      m_k_r     <= a_k_r;
      m_last_r  <= a_last_r;
      m_first_r <= a_first_r;
    end
  end

  // final: saturating accumulate, write back, output register
  logic [SW:0]   acc;
  logic [SW-1:0] sum_new;

  assign acc = {1'b0, m_sum_r} + (SW + 1)'(m_prod_r[2*MW-1:16]);
  assign sum_new = m_first_r ? '0 : (acc[SW] ? pwv_pkg::SUM_MAX : acc[SW-1:0]);

  always_ff @(posedge clk) begin
    if (en && m_v_r) begin
      mean_mem[m_pos_r] <= m_mean_r;
      dev_mem[m_pos_r]  <= sum_new;
    end
  end

  logic [pwv_pkg::IDX_W-1:0]  o_idx_r;
  logic [MW-1:0]              o_mean_r;
  logic [SW-1:0]              o_sum_r;
  logic [pwv_pkg::FRM_W-1:0]  o_frm_r;
  logic                       o_last_r, o_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= m_v_r;
    end
    if (en) begin
      o_idx_r  <= pwv_pkg::IDX_W'(m_pos_r);
      o_mean_r <= m_mean_r;
      o_sum_r  <= sum_new;
      o_frm_r  <= pwv_pkg::FRM_W'(m_k_r);
      o_last_r <= m_last_r;
      o_sat_r  <= (32'(m_k_r) == MAX_FRAMES);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {o_frm_r, o_sum_r, o_mean_r, o_idx_r};
  assign out_tlast  = o_last_r;
  assign out_tuser  = o_sat_r;

  // checks
  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (en && m_v_r && m_first_r) |-> (sum_new == '0))
    else $error("first frame sum not zero");

  a_restart_k1: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser[0]) |=> (frames_r == KW'(1)))
    else $error("restart did not reset frame count");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (en && m_v_r && accept) |-> (m_pos_r != pos_use))
    else $error("read of an entry still being written");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(m_v_r) && $stable(s1_v_r)))
    else $error("pipeline moved while stalled");

endmodule
